// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the sliding window min/max RTL.
// No dependencies; taken in by `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SWMM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted.
`define SWMM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/swmm_pkg.sv -----
// Package for the sliding window min/max core: default sizes and register constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;

  // window_size register
  localparam int             CFG_W         = 7;
  localparam logic [CFG_W-1:0] WIN_SIZE_RST = 7'd1;

endpackage

`default_nettype wire

// ----- rtl/core/swmm_if.sv -----
// Valid/ready channel interfaces for the sliding window min/max core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface swmm_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swmm_out_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [SAMPLE_BITS-1:0] window_max;

  modport source (output valid, output window_min, output window_max, input ready);
  modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sliding_window_min_max_core.sv -----
// Sliding window min/max over a signed sample stream.
// Result path: a word moves into the out_ch output register when that register is empty
//   or draining (the cells update on the edge that accepts its sample, the register later).
// Throughput: one sample per cycle while out_ch drains; the chain of cells folds each
//   sample into all running extremes at once, and in_ch.ready drops while a word waits.
// Reset (rst_n low, synchronous): window empty, sample count zero, window_size = 1.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sliding_window_min_max_core #(
  parameter int WINDOW_MAX  = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  swmm_in_if.sink                        in_ch,
  swmm_out_if.source                     out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [swmm_pkg::CFG_W-1:0] cfg_wdata
);
  import swmm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = $clog2(WINDOW_MAX);

  // Architecture
  //   Cell k holds max and min over the samples of age 0..k. On each accepted word
  //   every cell takes the new sample and its left neighbor's pair, so all cells
  //   update in parallel. Cell 0 takes the sample itself.
  //   win_len_r counts the ages that are still inside the window. It grows by one a
  //   word, is capped by the current window size (a shrink drops the old ages at
  //   once, a growth refills one age a word), and drops to one on start_req.
  //   The result for a word is cell (win_len - 1).

  logic [CFG_W-1:0] win_size_r;      // configuration register
  logic [CNT_W-1:0] eff_win;         // window size clamped to 1..WINDOW_MAX
  logic [CNT_W-1:0] win_len_r;
  logic [CNT_W-1:0] win_len_nxt;
  logic [CNT_W-1:0] seen_r;          // words since start, saturating
  logic [CNT_W-1:0] seen_nxt;
  logic [CNT_W:0]   len_inc;
  logic             pend_r;          // a result word waits in the cells
  logic             pend_nxt;
  logic [IDX_W-1:0] sel_r;
  logic [IDX_W-1:0] sel_nxt;
  logic             in_acc;
  logic             take;

  logic signed [SAMPLE_BITS-1:0] cell_max [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cell_min [WINDOW_MAX];

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= WIN_SIZE_RST;
    end else if (cfg_we) begin
      win_size_r <= cfg_wdata;
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (win_size_r == '0) begin
      eff_win = CNT_W'(1);
    end else if (int'(win_size_r) > WINDOW_MAX) begin
      eff_win = CNT_W'(WINDOW_MAX);
    end else begin
      eff_win = CNT_W'(win_size_r);
    end
  end

  // ---------------- window bookkeeping ----------------
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign len_inc = {1'b0, win_len_r} + 1'b1;

  always_comb begin
    if (in_ch.start_req) begin
      win_len_nxt = CNT_W'(1);
      seen_nxt    = CNT_W'(1);
    end else begin
      win_len_nxt = (len_inc < {1'b0, eff_win}) ? CNT_W'(len_inc) : eff_win;
      seen_nxt    = (int'(seen_r) == WINDOW_MAX) ? seen_r : seen_r + 1'b1;
    end
    sel_nxt  = IDX_W'(win_len_nxt - 1'b1);
    // partial window: no word
    pend_nxt = (seen_nxt >= eff_win);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= '0;
      seen_r    <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        win_len_r <= win_len_nxt;
        seen_r    <= seen_nxt;
        pend_r    <= pend_nxt;
      end else if (take) begin
        pend_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sel_r <= sel_nxt;
    end
  end

  // accept while nothing waits in the cells, or while it moves out this cycle
  assign in_ch.ready = !pend_r || take;

  // ---------------- chain of cells ----------------
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      swmm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk        (clk),
        .en         (in_acc),
        .din        (in_ch.sample),
        .prev_max   (in_ch.sample),
        .prev_min   (in_ch.sample),
        .hold_max_r (cell_max[k]),
        .hold_min_r (cell_min[k])
      );
    end else begin : g_body
      swmm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk        (clk),
        .en         (in_acc),
        .din        (in_ch.sample),
        .prev_max   (cell_max[k-1]),
        .prev_min   (cell_min[k-1]),
        .hold_max_r (cell_max[k]),
        .hold_min_r (cell_min[k])
      );
    end
  end

  // ---------------- result register ----------------
  logic                          out_valid_w;
  logic signed [SAMPLE_BITS-1:0] win_min_w;
  logic signed [SAMPLE_BITS-1:0] win_max_w;

  swmm_out_stage #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .cell_max    (cell_max),
    .cell_min    (cell_min),
    .pend        (pend_r),
    .sel         (sel_r),
    .out_ready   (out_ch.ready),
    .take        (take),
    .out_valid_r (out_valid_w),
    .win_min_r   (win_min_w),
    .win_max_r   (win_max_w)
  );

  assign out_ch.valid      = out_valid_w;
  assign out_ch.window_min = win_min_w;
  assign out_ch.window_max = win_max_w;

  // ---------------- checks ----------------
  `SWMM_ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, (win_len_r <= eff_win) || (win_len_r <= seen_r))
  `SWMM_ASSERT_IMPL(a_pend_len, clk, rst_n, pend_r, win_len_r != '0)
  `SWMM_ASSERT_NEXT(a_start_len, clk, rst_n, in_acc && in_ch.start_req, win_len_r == CNT_W'(1))
  `SWMM_ASSERT_NEXT(a_pend_moves, clk, rst_n, pend_r && !out_valid_w, out_valid_w)

endmodule

`default_nettype wire

// ----- rtl/core/swmm_cell.sv -----
// One cell of the running extreme chain: holds max and min of ages 0..k.
// Depends on swmm_pkg (defaults only).
`timescale 1ns / 1ps
`default_nettype none

module swmm_cell #(
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [SAMPLE_BITS-1:0] din,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_max,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_min,
  output logic signed [SAMPLE_BITS-1:0]      hold_max_r,
  output logic signed [SAMPLE_BITS-1:0]      hold_min_r
);
  import swmm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] hold_max_nxt;
  logic signed [SAMPLE_BITS-1:0] hold_min_nxt;

  // fold the new sample into the neighbor's extremes (one age older)
  always_comb begin
    hold_max_nxt = (din > prev_max) ? din : prev_max;
    hold_min_nxt = (din < prev_min) ? din : prev_min;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hold_max_r <= hold_max_nxt;
      hold_min_r <= hold_min_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/swmm_out_stage.sv -----
// Result stage: picks the chain cell for the live window and registers the word.
// Depends on swmm_pkg (defaults only).
`timescale 1ns / 1ps
`default_nettype none

module swmm_out_stage #(
  parameter int WINDOW_MAX  = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF,
  localparam int IDX_W      = $clog2(WINDOW_MAX)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic signed [SAMPLE_BITS-1:0] cell_max [WINDOW_MAX],
  input  wire logic signed [SAMPLE_BITS-1:0] cell_min [WINDOW_MAX],
  input  wire logic                          pend,
  input  wire logic [IDX_W-1:0]              sel,
  input  wire logic                          out_ready,
  output logic                               take,
  output logic                               out_valid_r,
  output logic signed [SAMPLE_BITS-1:0]      win_min_r,
  output logic signed [SAMPLE_BITS-1:0]      win_max_r
);
  import swmm_pkg::*;

  // move the pending word when the output register is empty or draining
  assign take = pend && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win_min_r <= cell_min[sel];
      win_max_r <= cell_max[sel];
    end
  end

endmodule

`default_nettype wire

// ----- tb/swmm_window_checker.sv -----
// Scoreboard for the sliding window min/max core: tracks both channels,
// predicts each result word and compares it. Needs swmm_pkg and swmm_if.
`timescale 1ns / 1ps

module swmm_window_checker #(
  parameter int WINDOW_MAX  = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  swmm_in_if                         mon_in,
  swmm_out_if                        mon_out,
  input  logic                       cfg_we,
  input  logic [swmm_pkg::CFG_W-1:0] cfg_wdata,
  output int                         pending_words,
  output int                         fail_count
);

  localparam int TAG_MOD = 2 * WINDOW_MAX;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct {
    sample_t val;
    int      tag;
  } cand_t;
  typedef struct {
    sample_t lo;
    sample_t hi;
  } extremes_t;

  cand_t     max_cands[$];
  cand_t     min_cands[$];
  extremes_t due_extremes[$];

  logic [swmm_pkg::CFG_W-1:0] win_size;
  int next_tag;
  int seen;
  int errors = 0;

  function automatic int age_of(input int tag);
    return (next_tag + TAG_MOD - tag) % TAG_MOD;
  endfunction

  task automatic fold_sample(input sample_t s, input logic restart);
    int        span;
    cand_t     entry;
    extremes_t pair;
    span = (win_size == 0) ? 1 : (win_size > WINDOW_MAX) ? WINDOW_MAX : int'(win_size);
    if (restart) begin
      max_cands.delete();
      min_cands.delete();
      next_tag = 0;
      seen     = 0;
    end
    // expire fronts too old for the current span
    while (max_cands.size() > 0 && age_of(max_cands[0].tag) >= span)
      max_cands.delete(0);
    while (min_cands.size() > 0 && age_of(min_cands[0].tag) >= span)
      min_cands.delete(0);
    // dominated tails go; ties stay
    while (max_cands.size() > 0 && max_cands[max_cands.size()-1].val < s)
      max_cands.delete(max_cands.size() - 1);
    while (min_cands.size() > 0 && min_cands[min_cands.size()-1].val > s)
      min_cands.delete(min_cands.size() - 1);
    entry.val = s;
    entry.tag = next_tag;
    max_cands = {max_cands, entry};
    min_cands = {min_cands, entry};
    next_tag = (next_tag + 1) % TAG_MOD;
    if (seen < WINDOW_MAX) seen++;
    if (seen >= span) begin
      pair.lo      = min_cands[0].val;
      pair.hi      = max_cands[0].val;
      due_extremes = {due_extremes, pair};
    end
  endtask

  always @(posedge clk) begin : watch
    extremes_t want;
    if (!rst_n) begin
      max_cands.delete();
      min_cands.delete();
      due_extremes.delete();
      next_tag = 0;
      seen     = 0;
      win_size = swmm_pkg::WIN_SIZE_RST;
    end else begin
      if (mon_out.valid && mon_out.ready) begin
        if (due_extremes.size() == 0) begin
          $error("unexpected result word: window_min %0d window_max %0d",
                 mon_out.window_min, mon_out.window_max);
          errors++;
        end else begin
          want = due_extremes[0];
          due_extremes.delete(0);
          if (mon_out.window_min !== want.lo) begin
            $error("window_min: expected %0d, actual %0d", want.lo, mon_out.window_min);
            errors++;
          end
          if (mon_out.window_max !== want.hi) begin
            $error("window_max: expected %0d, actual %0d", want.hi, mon_out.window_max);
            errors++;
          end
        end
      end
      if (cfg_we) win_size = cfg_wdata;
      if (mon_in.valid && mon_in.ready) fold_sample(mon_in.sample, mon_in.start_req);
    end
    pending_words <= due_extremes.size();
    fail_count    <= errors;
  end

endmodule

// ----- tb/tb_sliding_window_min_max_core.sv -----
// Top of the sliding window min/max testbench: clock, reset, sample and
// window-size stimulus, result back-pressure and the verdict.
// Needs swmm_pkg, swmm_if, the core and swmm_window_checker.
`timescale 1ns / 1ps

module tb_sliding_window_min_max_core;
  import swmm_pkg::*;

  localparam int WINDOW_MAX   = WINDOW_MAX_DEF;
  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int TOTAL_WORDS  = 720;     // directed opener plus ~700 random words
  localparam int CALM_AFTER   = 600;     // no idling on either side past this count
  localparam int DRAIN_CYCLES = 8;       // margin for words in flight with no result
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t MOST_POS = ~MOST_NEG;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int      pending_words;
  int      fail_count;
  int      cycles     = 0;
  int      idle_pct   = 25;   // chance per word / per cycle that a stall burst starts
  int      words_sent = 0;
  sample_t ramp       = '0;
  int      ramp_dir   = 1;

  swmm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  swmm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  sliding_window_min_max_core #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  swmm_window_checker #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .mon_in       (in_ch),
    .mon_out      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .pending_words(pending_words),
    .fail_count   (fail_count)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a lost result word ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side back-pressure: random bursts of low ready.
  initial begin : result_ready
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(1, 100) <= idle_pct) begin
        gap = $urandom_range(1, 8);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // One sample word, with an optional gap in front. Returns at the edge that
  // accepted it; valid stays high so back-to-back words stream at full rate.
  // ready is read right after the edge, i.e. the value the edge sampled.
  task automatic send_word(input sample_t s, input logic restart);
    if ($urandom_range(1, 100) <= idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= s;
    in_ch.start_req <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Wait out every predicted word, then the pipeline depth, since a word in a
  // partial window leaves nothing to wait for but may still be in flight.
  task automatic drain();
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // window_size is only written with the core idle.
  task automatic set_window(input logic [CFG_W-1:0] w);
    in_ch.valid <= 1'b0;
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample flavors: full random, a narrow band (lots of ties), a monotonic
  // ramp (deques grow or collapse), and the two's complement corners.
  function automatic sample_t pick_sample(input int style);
    case (style)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 6)) - 3;
      2: begin
        if ($urandom_range(0, 15) == 0) ramp_dir = -ramp_dir;
        ramp = ramp + ramp_dir * int'($urandom_range(0, 3));
        return ramp;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return '0;
          3: return '1;
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    int               run3[10];
    logic [CFG_W-1:0] w;
    int               style;
    int               len;
    logic             fresh;

    run3 = '{5, 5, 5, 1, 2, 3, 4, 9, 8, 7};

    in_ch.valid     = 1'b0;
    in_ch.sample    = '0;
    in_ch.start_req = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Window of 1 straight out of reset: corners and alternating bit patterns,
    // every word gives a result equal to itself.
    send_word(MOST_NEG, 1'b1);
    send_word(MOST_POS, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(sample_t'(32'h5555_5555), 1'b0);
    send_word(sample_t'(32'hAAAA_AAAA), 1'b0);

    // Grow to 3 mid-stream: equal values, rising run, falling run.
    set_window(CFG_W'(3));
    foreach (run3[i]) send_word(sample_t'(run3[i]), 1'b0);

    // Zero acts as a window of 1.
    set_window('0);
    send_word(-7, 1'b0);
    send_word(7, 1'b0);

    // All ones saturates to WINDOW_MAX; a fresh start leaves a partial window.
    set_window('1);
    send_word(3, 1'b1);
    send_word(-3, 1'b0);
    send_word('0, 1'b0);

    // Random phases: a new window size each time, sometimes with a fresh start,
    // sometimes mid-stream so a shrink expires old fronts and a grow holds
    // results back. Long phases without a start wrap the position tags.
    while (words_sent < TOTAL_WORDS) begin
      case ($urandom_range(0, 9))
        0: w = CFG_W'(WINDOW_MAX);
        1: begin
          case ($urandom_range(0, 3))
            0: w = '0;
            1: w = '1;
            2: w = CFG_W'(WINDOW_MAX + 1);
            default: w = CFG_W'($urandom_range(WINDOW_MAX + 2, 126));
          endcase
        end
        2: w = CFG_W'($urandom_range(13, WINDOW_MAX - 1));
        default: w = CFG_W'($urandom_range(1, 12));
      endcase
      len = $urandom_range(10, 50);
      if (w == 0 || w > 12) len += WINDOW_MAX;   // enough to fill a wide window
      style = $urandom_range(0, 3);
      fresh = ($urandom_range(0, 1) == 1);
      set_window(w);
      if (words_sent >= CALM_AFTER) begin
        idle_pct = 0;
      end else begin
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
      end
      for (int i = 0; i < len; i++) begin
        send_word(pick_sample(style), (i == 0) ? fresh : ($urandom_range(0, 49) == 0));
      end
    end

    in_ch.valid <= 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
